// File: src/assert_macros.svh
// Assertion macros for the sorted priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// File: src/spq_pkg.sv
// Types, codes and helpers shared by the sorted priority queue modules.
`default_nettype none
package spq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF    = 16;
   localparam int PRIO_BITS       = 8;
   localparam int IO_TAG_BITS     = 16;

   typedef enum logic [0:0] {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } op_type;

   localparam logic [2:0] CAT_P1    = 3'd0;
   localparam logic [2:0] CAT_P2    = 3'd1;
   localparam logic [2:0] CAT_P3    = 3'd2;
   localparam logic [2:0] CAT_ABOVE = 3'd3;
   localparam logic [2:0] CAT_NONE  = 3'd4;

   // broadcast to every cell of the chain
   typedef struct packed {
      op_type                 op;
      logic [PRIO_BITS-1:0]   prio;
   } cell_ctl_type;

   function automatic logic [2:0] category_of(input logic [PRIO_BITS-1:0] p);
      logic [2:0] c;
      if (p == PRIO_BITS'(1))      c = CAT_P1;
      else if (p == PRIO_BITS'(2)) c = CAT_P2;
      else if (p == PRIO_BITS'(3)) c = CAT_P3;
      else if (p > PRIO_BITS'(3))  c = CAT_ABOVE;
      else                         c = CAT_NONE;
      return c;
   endfunction

endpackage
`default_nettype wire

// File: src/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts toward tail or head.
`default_nettype none
module spq_cell #(
   parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  spq_pkg::cell_ctl_type      ctl,
   input  wire  [TAG_BITS-1:0]              new_tag,
   input  wire                              prev_shift,
   input  wire                              prev_valid,
   input  wire  [TAG_BITS-1:0]              prev_tag,
   input  wire  [spq_pkg::PRIO_BITS-1:0]    prev_prio,
   input  wire                              next_valid,
   input  wire  [TAG_BITS-1:0]              next_tag,
   input  wire  [spq_pkg::PRIO_BITS-1:0]    next_prio,
   output logic                             shift,
   output logic                             valid,
   output logic [TAG_BITS-1:0]              tag,
   output logic [spq_pkg::PRIO_BITS-1:0]    prio
);

   logic                           valid_ff, valid_in;
   logic [TAG_BITS-1:0]            tag_ff, tag_in;
   logic [spq_pkg::PRIO_BITS-1:0]  prio_ff, prio_in;

   // entry stays put only if it is valid and ranks at or above the newcomer
   assign shift = !(valid_ff && (prio_ff >= ctl.prio));

   always_comb begin
      valid_in = valid_ff;
      tag_in   = tag_ff;
      prio_in  = prio_ff;
      unique case (ctl.op)
         spq_pkg::OP_INSERT: begin
            if (shift) begin
               if (prev_shift) begin
                  valid_in = prev_valid;
                  tag_in   = prev_tag;
                  prio_in  = prev_prio;
               end else begin
                  valid_in = 1'b1;
                  tag_in   = new_tag;
                  prio_in  = ctl.prio;
               end
            end
         end
         spq_pkg::OP_REMOVE: begin
            valid_in = next_valid;
            tag_in   = next_tag;
            prio_in  = next_prio;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
   end

   assign valid = valid_ff;
   assign tag   = tag_ff;
   assign prio  = prio_ff;

endmodule
`default_nettype wire

// File: src/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, count and result register.
//
//  channel | dir | tvalid/tready | tdata                        | tuser
//  req     | in  | req_t*        | tag, priority_req            | req_type
//  rsp     | out | rsp_t*        | out_tag, out_priority,       | status
//          |     |               | category, now_empty, occupancy|
//
//  One transfer per cycle unless a stalled result holds: every cell compares
//  with the new priority in parallel and shifts one slot, and the result of
//  each request goes straight into the result register. Synchronous reset
//  clears the valid bits and the count. A stalled result holds; a new
//  request is taken in the cycle the held result leaves.
`default_nettype none
`include "assert_macros.svh"
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // tag[15:0], priority_req[23:16]
   input  wire  [0:0]  req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // out_tag[15:0], out_priority[23:16],
                                    // category[26:24], now_empty[27],
                                    // occupancy[32:28], zero[39:33]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int PB       = spq_pkg::PRIO_BITS;

   logic                 accept;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 is_full, is_empty;
   spq_pkg::cell_ctl_type ctl;
   logic [TAG_BITS-1:0]  new_tag;
   logic [63:0]          tag_wide;
   logic [63:0]          head_wide;
   logic [63:0]          count_wide;

   logic                 cell_shift [QUEUE_DEPTH];
   logic                 cell_valid [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  cell_tag   [QUEUE_DEPTH];
   logic [PB-1:0]        cell_prio  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_vec;

   logic                 rsp_valid_ff;
   spq_pkg::status_type  status_ff, status_in;
   logic [15:0]          otag_ff, otag_in;
   logic [PB-1:0]        oprio_ff, oprio_in;
   logic [2:0]           cat_ff, cat_in;
   logic                 empty_ff, empty_in;
   logic [4:0]           occ_ff, occ_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign is_empty   = (count_ff == '0);

   assign tag_wide = {48'd0, req_tdata[15:0]};
   assign new_tag  = tag_wide[TAG_BITS-1:0];

   always_comb begin
      ctl.prio = req_tdata[23:16];
      ctl.op   = spq_pkg::OP_HOLD;
      if (accept) begin
         if (spq_pkg::req_kind_type'(req_tuser[0]) == spq_pkg::REQ_ENQUEUE) begin
            if (!is_full) ctl.op = spq_pkg::OP_INSERT;
         end else begin
            if (!is_empty) ctl.op = spq_pkg::OP_REMOVE;
         end
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic                pshift, pvalid, nvalid;
         logic [TAG_BITS-1:0] ptag, ntag;
         logic [PB-1:0]       pprio, nprio;
         if (gi == 0) begin : g_head
            assign pshift = 1'b0;
            assign pvalid = 1'b0;
            assign ptag   = '0;
            assign pprio  = '0;
         end else begin : g_mid
            assign pshift = cell_shift[gi-1];
            assign pvalid = cell_valid[gi-1];
            assign ptag   = cell_tag[gi-1];
            assign pprio  = cell_prio[gi-1];
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign nvalid = 1'b0;
            assign ntag   = '0;
            assign nprio  = '0;
         end else begin : g_body
            assign nvalid = cell_valid[gi+1];
            assign ntag   = cell_tag[gi+1];
            assign nprio  = cell_prio[gi+1];
         end
         spq_cell #(.TAG_BITS(TAG_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_tag    (new_tag),
            .prev_shift (pshift),
            .prev_valid (pvalid),
            .prev_tag   (ptag),
            .prev_prio  (pprio),
            .next_valid (nvalid),
            .next_tag   (ntag),
            .next_prio  (nprio),
            .shift      (cell_shift[gi]),
            .valid      (cell_valid[gi]),
            .tag        (cell_tag[gi]),
            .prio       (cell_prio[gi])
         );
         assign valid_vec[gi] = cell_valid[gi];
      end
   endgenerate

   assign head_wide = 64'(cell_tag[0]);

   always_comb begin
      count_in = count_ff;
      unique case (ctl.op)
         spq_pkg::OP_INSERT: count_in = count_ff + CNT_BITS'(1);
         spq_pkg::OP_REMOVE: count_in = count_ff - CNT_BITS'(1);
         default:            count_in = count_ff;
      endcase
   end

   assign count_wide = 64'(count_in);

   always_comb begin
      otag_in  = '0;
      oprio_in = '0;
      cat_in   = spq_pkg::CAT_NONE;
      if (spq_pkg::req_kind_type'(req_tuser[0]) == spq_pkg::REQ_ENQUEUE) begin
         status_in = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQUEUED;
      end else if (is_empty) begin
         status_in = spq_pkg::ST_EMPTY;
      end else begin
         status_in = spq_pkg::ST_DEQUEUED;
         otag_in   = head_wide[15:0];
         oprio_in  = cell_prio[0];
         cat_in    = spq_pkg::category_of(cell_prio[0]);
      end
      empty_in = (count_in == '0);
      occ_in   = count_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff <= status_in;
         otag_ff   <= otag_in;
         oprio_ff  <= oprio_in;
         cat_ff    <= cat_in;
         empty_ff  <= empty_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {7'd0, occ_ff, empty_ff, cat_ff, oprio_ff, otag_ff};

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= CNT_BITS'(QUEUE_DEPTH))
   `ASSERT_CLK(a_valid_matches_count, clock, reset, $countones(valid_vec) == 32'(count_ff))
   `ASSERT_NEXT(a_remove_decrements, clock, reset, ctl.op == spq_pkg::OP_REMOVE, count_ff == $past(count_ff) - CNT_BITS'(1))
   `ASSERT_NEXT(a_full_rejects, clock, reset, accept && is_full && !req_tuser[0], rsp_tuser == spq_pkg::ST_FULL && count_ff == CNT_BITS'(QUEUE_DEPTH))

endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for sorted_priority_queue: scoreboard class, stream drivers and result checks.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = spq_pkg::QUEUE_DEPTH_DEF;
   localparam int ITEM_TARGET = 450;
   localparam int CYCLE_LIMIT = 100000;

   typedef struct {
      spq_pkg::status_type status;
      logic [15:0]         tag;
      logic [7:0]          prio;
      logic [2:0]          cat;
      logic                empty;
      logic [4:0]          occ;
   } outcome_type;

   class queue_scoreboard;
      logic [15:0] held_tags[$];
      logic [7:0]  held_prios[$];
      outcome_type outcomes[$];
      int          mismatches;

      function void note_request(spq_pkg::req_kind_type kind, logic [15:0] tag,
                                 logic [7:0] prio);
         outcome_type o;
         int          pos;
         o.tag  = '0;
         o.prio = '0;
         o.cat  = spq_pkg::CAT_NONE;
         if (kind == spq_pkg::REQ_ENQUEUE) begin
            if (held_prios.size() >= DEPTH) begin
               o.status = spq_pkg::ST_FULL;
            end else begin
               pos = 0;
               while (pos < held_prios.size() && held_prios[pos] >= prio) pos++;
               held_prios.insert(pos, prio);
               held_tags.insert(pos, tag);
               o.status = spq_pkg::ST_ENQUEUED;
            end
         end else if (held_prios.size() == 0) begin
            o.status = spq_pkg::ST_EMPTY;
         end else begin
            o.tag    = held_tags.pop_front();
            o.prio   = held_prios.pop_front();
            o.status = spq_pkg::ST_DEQUEUED;
            if (o.prio > 8'd3) o.cat = spq_pkg::CAT_ABOVE;
            else if (o.prio == 8'd3) o.cat = spq_pkg::CAT_P3;
            else if (o.prio == 8'd2) o.cat = spq_pkg::CAT_P2;
            else if (o.prio == 8'd1) o.cat = spq_pkg::CAT_P1;
         end
         o.empty = (held_prios.size() == 0);
         o.occ   = 5'(held_prios.size());
         outcomes.push_back(o);
      endfunction

      function void check_response(logic [1:0] status, logic [39:0] data);
         outcome_type o;
         if (outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: status %0d data %h", status, data);
            return;
         end
         o = outcomes.pop_front();
         if (status !== o.status || data[15:0] !== o.tag || data[23:16] !== o.prio ||
             data[26:24] !== o.cat || data[27] !== o.empty || data[32:28] !== o.occ) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("mismatch (exp/act): status %0d/%0d tag %h/%h prio %0d/%0d ",
                      o.status, status, o.tag, data[15:0], o.prio, data[23:16]);
               $display("cat %0d/%0d empty %b/%b occ %0d/%0d",
                        o.cat, data[26:24], o.empty, data[27], o.occ, data[32:28]);
            end
         end
      endfunction

      function int pending();
         return outcomes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // tag[15:0], priority_req[23:16]
   logic [0:0]  req_tuser = '0;   // req_type[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // out_tag, out_priority, category, now_empty, occupancy
   logic [1:0]  rsp_tuser;        // status[1:0]

   queue_scoreboard sb = new();
   bit send_quiet = 1'b0;
   int cycles = 0;

   logic [15:0] dir_tags[17] = '{16'h0000, 16'hffff, 16'h1234, 16'h0002, 16'h0003, 16'h0004,
                                 16'ha5a5, 16'h5a5a, 16'h0001, 16'h0007, 16'h0008, 16'h0009,
                                 16'h000a, 16'h000b, 16'h000c, 16'h000d, 16'hbeef};
   logic [7:0]  dir_prios[17] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd4, 8'd255, 8'd0,
                                  8'd128, 8'd127, 8'd1, 8'd2, 8'd3, 8'd0, 8'd254, 8'd200};

   sorted_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   task automatic send_item(spq_pkg::req_kind_type kind, logic [15:0] tag, logic [7:0] prio);
      int gap;
      if ($urandom_range(0, 99) < 5) send_quiet = !send_quiet;
      gap = send_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, tag};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, tag, prio);
   endtask

   initial begin
      int                    sent;
      int                    enq_pct;
      int                    run;
      spq_pkg::req_kind_type kind;
      logic [7:0]            prio;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // dequeue on empty, fill with ties and extremes, overflow, partial drain
      send_item(spq_pkg::REQ_DEQUEUE, 16'hffff, 8'hff);
      for (int i = 0; i < 17; i++) send_item(spq_pkg::REQ_ENQUEUE, dir_tags[i], dir_prios[i]);
      repeat (7) send_item(spq_pkg::REQ_DEQUEUE, 16'h0000, 8'h00);

      sent = 0;
      while (sent < ITEM_TARGET) begin
         case ($urandom_range(0, 2))
            0: enq_pct = 85;
            1: enq_pct = 50;
            default: enq_pct = 15;
         endcase
         run = $urandom_range(10, 40);
         repeat (run) begin
            kind = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::REQ_ENQUEUE
                                                     : spq_pkg::REQ_DEQUEUE;
            if ($urandom_range(0, 9) < 7) prio = 8'($urandom_range(0, 5));
            else prio = 8'($urandom_range(0, 255));
            send_item(kind, 16'($urandom_range(0, 65535)), prio);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // receiver: random stalls, quiet stretches, one long hold to back up the input
   initial begin
      int stall;
      int seen;
      bit held;
      bit quiet;
      stall = 0;
      seen  = 0;
      held  = 1'b0;
      quiet = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tuser, rsp_tdata);
            seen++;
         end
         if ($urandom_range(0, 99) < 2) quiet = !quiet;
         if (stall == 0 && !held && seen >= 80) begin
            held  = 1'b1;
            stall = 300;
         end else if (stall == 0 && !quiet) begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
   end

endmodule
